[hw/rtl/dps_pkg.sv]
package dps_pkg;

   // Sequencer state codes
   localparam logic [2:0] SEQ_RESET  = 3'd0;
   localparam logic [2:0] SEQ_IDLE   = 3'd1;
   localparam logic [2:0] SEQ_DETECT = 3'd2;
   localparam logic [2:0] SEQ_LOCK   = 3'd3;
   localparam logic [2:0] SEQ_OFF    = 3'd4;
   localparam logic [2:0] SEQ_ON     = 3'd5;

   // I2C target bus phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_REG  = 3'd1;
   localparam logic [2:0] PH_SIZE = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_SEND = 3'd4;
   localparam logic [2:0] PH_ACK  = 3'd5;

   // Request kinds
   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_WR_START = 3'd1;
   localparam logic [2:0] ACT_RX_BYTE  = 3'd2;
   localparam logic [2:0] ACT_RD_START = 3'd3;
   localparam logic [2:0] ACT_TX_DONE  = 3'd4;
   localparam logic [2:0] ACT_BUS_ERR  = 3'd5;

   // LED colours
   localparam logic [1:0] LED_OFF   = 2'd0;
   localparam logic [1:0] LED_WHITE = 2'd1;
   localparam logic [1:0] LED_RED   = 2'd2;

   // External board requests
   localparam logic [1:0] BRD_NONE = 2'd0;
   localparam logic [1:0] BRD_ON   = 2'd1;
   localparam logic [1:0] BRD_OFF  = 2'd2;

   // I2C command bytes and replies
   localparam logic [7:0] CMD_WRITE   = 8'hA0;
   localparam logic [7:0] CMD_IRQ_ACK = 8'hA1;
   localparam logic [7:0] CMD_ENABLE  = 8'hA2;
   localparam logic [7:0] CMD_VERSION = 8'hA3;
   localparam logic [7:0] CMD_IGNORE  = 8'hE6;
   localparam logic [7:0] REPLY_ACK   = 8'hDC;
   localparam logic [7:0] EN_DISABLED = 8'hFF;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   typedef struct packed {
      logic [2:0] seq;
      logic [2:0] phase;
      logic [7:0] command;
      logic [7:0] reg_index;
      logic [7:0] xfer_len;
      logic [7:0] bytes_seen;
      logic [7:0] first_byte;
      logic [7:0] enable;
      logic [7:0] reply;
      logic [1:0] led;
      logic       lock_line;
      logic       power;
      logic       irq;
      logic       board_present;
   } dps_state_type;

   typedef struct packed {
      logic [2:0] action;
      logic       cable_present;
      logic       lock_closed;
      logic       host_power_enable;
      logic       board_detect;
      logic [7:0] rx_byte;
   } dps_item_type;

   typedef struct packed {
      logic [2:0] seq_state;
      logic [1:0] led_colour;
      logic       lock_detect_out;
      logic       pcie_power_on;
      logic       host_irq;
      logic [1:0] board_request;
      logic       tx_valid;
      logic [7:0] tx_byte;
   } dps_result_type;

endpackage

[hw/rtl/dps_core.sv]
module dps_core (
   input  dps_pkg::dps_state_type  state,
   input  dps_pkg::dps_item_type   item,
   output dps_pkg::dps_state_type  state_next,
   output dps_pkg::dps_result_type result
);
   import dps_pkg::*;

   logic       en;
   logic       go;
   logic [2:0] target;
   logic [2:0] prev;
   logic [1:0] brd_req;
   logic [1:0] go_req;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic [7:0] seen_inc;
   logic [7:0] first_byte;

   assign en   = (state.enable != 8'd0);
   assign prev = state.seq;

   // Pick the sequencer target for a tick
   always_comb begin
      go     = 1'b0;
      target = prev;
      case (prev)
         SEQ_IDLE: begin
            if (!en) begin
               go = 1'b1; target = SEQ_DETECT;
            end
         end
         SEQ_DETECT: begin
            if (en) begin
               go = 1'b1; target = SEQ_IDLE;
            end else if (item.cable_present) begin
               go = 1'b1; target = SEQ_LOCK;
            end
         end
         SEQ_LOCK: begin
            if (en) begin
               go = 1'b1; target = SEQ_IDLE;
            end else if (!item.cable_present) begin
               go = 1'b1; target = SEQ_DETECT;
            end else if (item.lock_closed) begin
               go = 1'b1; target = SEQ_OFF;
            end
         end
         SEQ_OFF: begin
            if (en) begin
               go = 1'b1; target = SEQ_IDLE;
            end else if (!item.cable_present) begin
               go = 1'b1; target = SEQ_DETECT;
            end else if (!item.lock_closed) begin
               go = 1'b1; target = SEQ_LOCK;
            end else if (item.host_power_enable) begin
               go = 1'b1; target = SEQ_ON;
            end
         end
         SEQ_ON: begin
            if (en) begin
               go = 1'b1; target = SEQ_IDLE;
            end else if (!item.cable_present) begin
               go = 1'b1; target = SEQ_DETECT;
            end else if (!item.lock_closed) begin
               go = 1'b1; target = SEQ_LOCK;
            end else if (!item.host_power_enable) begin
               go = 1'b1; target = SEQ_OFF;
            end
         end
         default: begin
            go = 1'b0; target = prev;
         end
      endcase
   end

   // Raw board request for a transition
   always_comb begin
      go_req = BRD_NONE;
      if (target == SEQ_OFF && prev < target) go_req = BRD_ON;
      else if (target <= SEQ_DETECT && prev > target) go_req = BRD_OFF;
   end

   // Data phase counting
   assign seen_inc   = state.bytes_seen + 8'd1;
   assign first_byte = (state.bytes_seen == 8'd0) ? item.rx_byte : state.first_byte;

   // Apply the request to the state
   always_comb begin
      state_next = state;
      brd_req    = BRD_NONE;
      tx_valid   = 1'b0;
      tx_byte    = 8'd0;
      if (item.action == ACT_TICK) begin
         if (prev == SEQ_RESET) begin
            // first tick latches the board pin and, if a board is present, requests it off
            state_next.board_present = item.board_detect;
            state_next.seq           = SEQ_IDLE;
            state_next.enable        = EN_DISABLED;
            brd_req = item.board_detect ? BRD_OFF : BRD_NONE;
         end else if (go) begin
            if (target == SEQ_LOCK) state_next.led = LED_WHITE;
            else if (target == SEQ_ON && prev < target) state_next.led = LED_RED;
            else if (target < SEQ_LOCK && prev > target) state_next.led = LED_OFF;
            if (target > SEQ_LOCK && prev < target) state_next.lock_line = 1'b1;
            else if (target <= SEQ_LOCK && prev > target) state_next.lock_line = 1'b0;
            if (prev > SEQ_OFF && target <= SEQ_OFF) state_next.power = 1'b0;
            else if (prev < SEQ_ON && target >= SEQ_ON) state_next.power = 1'b1;
            if (prev < SEQ_LOCK && target >= SEQ_LOCK) state_next.irq = 1'b1;
            if (prev > SEQ_DETECT && target <= SEQ_DETECT) state_next.enable = EN_DISABLED;
            state_next.seq = target;
            brd_req = state.board_present ? go_req : BRD_NONE;
         end
      end else if (prev != SEQ_RESET) begin
         case (item.action)
            ACT_WR_START, ACT_TX_DONE, ACT_BUS_ERR: begin
               state_next.phase = PH_IDLE;
            end
            ACT_RD_START: begin
               if (state.phase == PH_SEND) begin
                  state_next.phase = PH_ACK;
                  tx_valid = 1'b1;
                  tx_byte  = state.reply;
               end else begin
                  state_next.phase = PH_IDLE;
               end
            end
            ACT_RX_BYTE: begin
               case (state.phase)
                  PH_IDLE: begin
                     state_next.command = item.rx_byte;
                     if (item.rx_byte == CMD_WRITE) begin
                        state_next.phase = PH_REG;
                     end else if (item.rx_byte inside {CMD_IRQ_ACK, CMD_ENABLE,
                                                       CMD_VERSION}) begin
                        state_next.reg_index = 8'd0;
                        state_next.xfer_len  = 8'd1;
                        state_next.phase     = PH_SEND;
                        if (item.rx_byte == CMD_IRQ_ACK) begin
                           state_next.irq   = 1'b0;
                           state_next.reply = REPLY_ACK;
                        end else if (item.rx_byte == CMD_ENABLE) begin
                           state_next.reply = en ? 8'd1 : 8'd2;
                        end else begin
                           state_next.reply = 8'd1;
                        end
                     end else begin
                        // unknown or ignored command byte
                        state_next.phase = PH_IDLE;
                     end
                  end
                  PH_REG: begin
                     state_next.reg_index = item.rx_byte;
                     state_next.phase     = PH_SIZE;
                  end
                  PH_SIZE: begin
                     state_next.xfer_len   = item.rx_byte;
                     state_next.bytes_seen = 8'd0;
                     state_next.phase      = PH_DATA;
                  end
                  PH_DATA: begin
                     state_next.first_byte = first_byte;
                     state_next.bytes_seen = seen_inc;
                     if (seen_inc >= state.xfer_len) begin
                        if (state.command == CMD_WRITE && state.xfer_len == 8'd1 &&
                            state.reg_index == 8'd1) begin
                           state_next.enable = first_byte;
                        end
                        state_next.bytes_seen = 8'd0;
                        state_next.phase      = PH_IDLE;
                     end
                  end
                  default: begin
                     // bytes during a pending reply are dropped
                     state_next.phase = state.phase;
                  end
               endcase
            end
            default: begin
               state_next.phase = state.phase;
            end
         endcase
      end
   end

   // Result after the step
   always_comb begin
      result.seq_state       = state_next.seq;
      result.led_colour      = state_next.led;
      result.lock_detect_out = state_next.lock_line;
      result.pcie_power_on   = state_next.power;
      result.host_irq        = state_next.irq;
      result.board_request   = brd_req;
      result.tx_valid        = tx_valid;
      result.tx_byte         = tx_byte;
   end

endmodule

[hw/rtl/dock_power_sequencer_with_i2c_slave.sv]
// A request taken into the request register passes the decision stage into the result
// register and is then offered on rsp_*.
// Throughput: one request per cycle, set by the single decision stage between the
// request register and the result register; rsp_tready low stalls that stage.
// Reset: synchronous, active high; sequencer in its reset state, I2C phase idle,
// enable register 0xff, both stages empty, rsp_tvalid low and req_tready high.
module dock_power_sequencer_with_i2c_slave (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] cable_present, [1] lock_closed, [2] host_power_enable, [3] board_detect,
   // [11:4] rx_byte, [15:12] zero
   input  logic [15:0] req_tdata,
   // [2:0] action
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] seq_state, [4:3] led_colour, [5] lock_detect_out, [6] pcie_power_on,
   // [7] host_irq, [9:8] board_request, [10] tx_valid, [18:11] tx_byte, [23:19] zero
   output logic [23:0] rsp_tdata
);
   import dps_pkg::*;

   logic           in_valid_ff, in_valid_in;
   dps_item_type   in_item_ff, in_item_in;
   logic           out_valid_ff, out_valid_in;
   dps_result_type out_ff, out_in;
   dps_state_type  state_ff, state_in;
   dps_state_type  core_state;
   dps_result_type core_result;
   logic           advance;
   logic           req_take;

   // Decision stage moves when it holds a request and the result slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Request register
   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_item_in.action            = req_tuser;
         in_item_in.cable_present     = req_tdata[0];
         in_item_in.lock_closed       = req_tdata[1];
         in_item_in.host_power_enable = req_tdata[2];
         in_item_in.board_detect      = req_tdata[3];
         in_item_in.rx_byte           = req_tdata[11:4];
      end
   end

   dps_core u_core (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (core_state),
      .result     (core_result)
   );

   // State and result register
   always_comb begin
      state_in     = advance ? core_state : state_ff;
      out_in       = advance ? core_result : out_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{seq: SEQ_RESET, phase: PH_IDLE, command: 8'd0,
                           reg_index: 8'd0, xfer_len: 8'd0, bytes_seen: 8'd0,
                           first_byte: 8'd0, enable: EN_DISABLED, reply: 8'd0,
                           led: LED_OFF, lock_line: 1'b0, power: 1'b0, irq: 1'b0,
                           board_present: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_ff     <= out_in;
   end

   // Result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.tx_byte, out_ff.tx_valid, out_ff.board_request,
                        out_ff.host_irq, out_ff.pcie_power_on, out_ff.lock_detect_out,
                        out_ff.led_colour, out_ff.seq_state};

endmodule
